[src/lff_pkg.sv]
// Shared constants, register codes and record types for the fixed-string line filter.
// No dependencies; every other file of the block imports this package.
package lff_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int LFF_MAX_PATTERN = 16;
    localparam int LFF_OFFSET_BITS = 32;

    // Fixed field widths.
    localparam int BYTE_BITS      = 8;
    localparam int PATTERN_SLOTS  = 16;
    localparam int LEN_BITS       = 5;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 64;
    localparam int OUT_FIELD_BITS = 32;
    localparam int HIT_BITS       = 16;

    // Depth of the request queue between the front and back halves.
    localparam int QUEUE_DEPTH = 2;

    // Special byte values.
    localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_BITS-1:0] ZERO_BYTE    = 8'h00;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic [LEN_BITS-1:0] PATTERN_LENGTH_RESET = 5'd1;
    localparam logic [HIT_BITS-1:0] HIT_MAX              = 16'hFFFF;

    // Classification of one text byte, produced by the front half.
    typedef struct packed {
        logic hit;
        logic newline;
        logic last;
    } lff_rec_t;

    // A record together with its valid flag.
    typedef struct packed {
        logic     valid;
        lff_rec_t rec;
    } lff_push_t;

endpackage

[src/lff_chan_if.sv]
// Handshake channels of the fixed-string line filter: text input, line results and
// configuration writes. Depends on lff_pkg for the field widths.
interface lff_in_if;
    import lff_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lff_out_if;
    import lff_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OUT_FIELD_BITS-1:0] line_offset;
    logic [OUT_FIELD_BITS-1:0] line_length;
    logic [HIT_BITS-1:0]       hit_count;

    modport source (output valid, output line_offset, output line_length, output hit_count,
                    input ready);
    modport sink (input valid, input line_offset, input line_length, input hit_count,
                  output ready);
endinterface

interface lff_cfg_if;
    import lff_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

[src/lff_front.sv]
// Front half: configuration registers, byte window and match detection.
// Classifies each accepted byte into a record for the queue. Depends on lff_pkg.
module lff_front #(
    parameter int MAX_PATTERN = lff_pkg::LFF_MAX_PATTERN
) (
    input  logic              clk,
    input  logic              rst_n,
    lff_in_if.sink            in_chan,
    lff_cfg_if.sink           cfg,
    input  logic              queue_full,
    output lff_pkg::lff_push_t push
);
    import lff_pkg::*;

    localparam int WIN      = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;
    localparam int BSH_BITS = $clog2(MAX_PATTERN + 1);
    localparam int CMP_BITS = (BSH_BITS > LEN_BITS) ? BSH_BITS : LEN_BITS;
    localparam logic [BSH_BITS-1:0] BSH_RESET = BSH_BITS'(WIN);
    localparam logic [BSH_BITS-1:0] BSH_MAX   = BSH_BITS'(MAX_PATTERN);
    localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(WIN);

    logic [CFG_DATA_BITS-1:0] pat_low_reg;
    logic [CFG_DATA_BITS-1:0] pat_high_reg;
    logic [LEN_BITS-1:0]      plen_reg;

    logic [BYTE_BITS-1:0] win_reg [WIN];
    logic [BYTE_BITS-1:0] win_next [WIN];
    logic [BSH_BITS-1:0]  bsh_reg;
    logic [BSH_BITS-1:0]  bsh_inc;
    logic [BSH_BITS-1:0]  bsh_next;
    logic                 halted_reg;
    logic                 halted_next;

    logic [BYTE_BITS-1:0] pat [PATTERN_SLOTS];
    logic [LEN_BITS-1:0]  len_clamp;
    logic [LEN_BITS-1:0]  first_zero;
    logic [LEN_BITS-1:0]  eff_len;
    logic [WIN:0]         m_vec;
    logic                 match;
    logic                 hit;
    logic                 accept;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            plen_reg     <= PATTERN_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg.reg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg.reg_data;
                CFG_PATTERN_LENGTH: plen_reg     <= cfg.reg_data[LEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Effective pattern length: clamped, then cut at the first zero pattern byte.
    always_comb
    begin
        for (int i = 0; i < PATTERN_SLOTS; i++)
        begin
            if (i < 8)
                pat[i] = pat_low_reg[BYTE_BITS*i +: BYTE_BITS];
            else
                pat[i] = pat_high_reg[BYTE_BITS*(i-8) +: BYTE_BITS];
        end

        if (plen_reg == '0)
            len_clamp = PATTERN_LENGTH_RESET;
        else if (plen_reg > LEN_LIMIT)
            len_clamp = LEN_LIMIT;
        else
            len_clamp = plen_reg;

        first_zero = LEN_BITS'(PATTERN_SLOTS);
        for (int i = PATTERN_SLOTS - 1; i >= 0; i--)
        begin
            if (pat[i] == ZERO_BYTE)
                first_zero = LEN_BITS'(i);
        end

        eff_len = (first_zero < len_clamp) ? first_zero : len_clamp;
    end

    // Window after taking the incoming byte, newest first.
    always_comb
    begin
        win_next[0] = in_chan.data_byte;
        for (int k = 1; k < WIN; k++)
            win_next[k] = win_reg[k-1];
    end

    // Compare the window against the pattern for every candidate length at once.
    always_comb
    begin
        m_vec = '0;
        for (int l = 1; l <= WIN; l++)
        begin
            m_vec[l] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (win_next[l-1-i] != pat[i])
                    m_vec[l] = 1'b0;
            end
        end

        match = 1'b0;
        for (int l = 1; l <= WIN; l++)
        begin
            if (eff_len == LEN_BITS'(l))
                match = m_vec[l];
        end
    end

    // Hit decision: not halted, far enough from the previous hit, window matches.
    always_comb
    begin
        halted_next = halted_reg | (in_chan.data_byte == ZERO_BYTE);
        bsh_inc     = (bsh_reg < BSH_MAX) ? bsh_reg + 1'b1 : bsh_reg;
        hit         = !halted_next && (CMP_BITS'(bsh_inc) >= CMP_BITS'(eff_len)) && match;
        bsh_next    = hit ? '0 : bsh_inc;
    end

    assign in_chan.ready = !queue_full;
    assign accept        = in_chan.valid && in_chan.ready;

    // Window and hit-spacing state; the end of a stream restores reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN; k++)
                win_reg[k] <= '0;
            bsh_reg    <= BSH_RESET;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_chan.last_byte)
            begin
                for (int k = 0; k < WIN; k++)
                    win_reg[k] <= '0;
                bsh_reg    <= BSH_RESET;
                halted_reg <= 1'b0;
            end
            else
            begin
                for (int k = 0; k < WIN; k++)
                    win_reg[k] <= win_next[k];
                bsh_reg    <= bsh_next;
                halted_reg <= halted_next;
            end
        end
    end

    // Record for the back half.
    always_comb
    begin
        push.valid       = accept;
        push.rec.hit     = hit;
        push.rec.newline = (in_chan.data_byte == NEWLINE_BYTE);
        push.rec.last    = in_chan.last_byte;
    end

    // A counted hit restarts the spacing count.
    a_hit_clears_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hit && !in_chan.last_byte) |=> (bsh_reg == '0))
        else $error("spacing count not cleared after a hit");

    // Spacing count never passes its saturation value.
    a_spacing_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bsh_reg <= BSH_MAX)
        else $error("spacing count above its limit");

endmodule

[src/lff_queue.sv]
// Short request queue between the front and back halves of the line filter.
// Holds classified byte records in order. Depends on lff_pkg.
module lff_queue #(
    parameter int DEPTH = lff_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lff_pkg::lff_push_t push,
    output logic               full,
    output lff_pkg::lff_push_t head,
    input  logic               pop
);
    import lff_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    lff_rec_t              rec_mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.rec   = rec_mem[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            rec_mem[wr_ptr_reg] <= push.rec;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // The front half must never offer a request into a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("request offered to a full queue");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill count above depth");

endmodule

[src/lff_back.sv]
// Back half: stream offset, line tracking and hit counting; builds line results.
// Takes records from lff_queue and drives the result channel. Depends on lff_pkg.
module lff_back #(
    parameter int OFFSET_BITS = lff_pkg::LFF_OFFSET_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lff_pkg::lff_push_t head,
    output logic               pop,
    lff_out_if.source          out_chan
);
    import lff_pkg::*;

    logic [OFFSET_BITS-1:0]    offset_reg;
    logic [OFFSET_BITS-1:0]    start_reg;
    logic [HIT_BITS-1:0]       hits_reg;
    logic                      out_valid_reg;
    logic [OUT_FIELD_BITS-1:0] line_offset_reg;
    logic [OUT_FIELD_BITS-1:0] line_length_reg;
    logic [HIT_BITS-1:0]       hit_count_reg;

    logic [OFFSET_BITS-1:0]    here_inc;
    logic [OFFSET_BITS-1:0]    end_off;
    logic [OFFSET_BITS-1:0]    span;
    logic [HIT_BITS-1:0]       hits_new;
    logic                      line_end;
    logic                      emit;
    logic                      slot_free;

    // Line bookkeeping for the record at the head of the queue.
    always_comb
    begin
        here_inc = offset_reg + 1'b1;
        if (head.rec.hit && (hits_reg != HIT_MAX))
            hits_new = hits_reg + 1'b1;
        else
            hits_new = hits_reg;
        line_end  = head.rec.newline || head.rec.last;
        end_off   = head.rec.newline ? offset_reg : here_inc;
        span      = end_off - start_reg;
        emit      = line_end && (hits_new != '0);
        slot_free = !out_valid_reg || out_chan.ready;
        pop       = head.valid && (!emit || slot_free);
    end

    // Offset, line start and hit count; the end of a stream clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            start_reg  <= '0;
            hits_reg   <= '0;
        end
        else if (pop)
        begin
            if (head.rec.last)
            begin
                offset_reg <= '0;
                start_reg  <= '0;
                hits_reg   <= '0;
            end
            else
            begin
                offset_reg <= here_inc;
                if (line_end)
                begin
                    start_reg <= here_inc;
                    hits_reg  <= '0;
                end
                else
                begin
                    hits_reg <= hits_new;
                end
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && emit)
            out_valid_reg <= 1'b1;
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            line_offset_reg <= OUT_FIELD_BITS'(start_reg);
            line_length_reg <= OUT_FIELD_BITS'(span);
            hit_count_reg   <= hits_new;
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.line_offset = line_offset_reg;
    assign out_chan.line_length = line_length_reg;
    assign out_chan.hit_count   = hit_count_reg;

    // Only lines that held a match produce a result.
    a_result_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hit_count_reg != '0))
        else $error("result issued with zero hits");

    // The final byte of a stream restarts the offset at zero.
    a_stream_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.rec.last) |=> (offset_reg == '0 && hits_reg == '0))
        else $error("stream state not cleared at end of stream");

endmodule

[src/line_filter_fixed_string_top.sv]
// Top level of the fixed-string line filter: front half, request queue, back half.
// Depends on lff_pkg, the channel interfaces, lff_front, lff_queue and lff_back.
//
//   Channel   | Direction | Payload                                   | Handshake
//   ----------+-----------+-------------------------------------------+-----------
//   in_bytes  | in        | data_byte[7:0], last_byte                 | valid/ready
//   out_lines | out       | line_offset[31:0], line_length[31:0],     | valid/ready
//             |           | hit_count[15:0]                           |
//   cfg       | in        | reg_index[1:0], reg_data[63:0]            | valid/ready
//
// One text byte is taken every cycle while the queue is not full; the window compare for
// all pattern lengths runs in the cycle the byte is accepted.
// A result is registered when the record of the newline or final byte closing its line
// leaves the queue after any older requests, once the result register is free.
// Reset is asynchronous and active low; it clears the pattern registers to length one.
// A stalled result output holds back only the back half; the queue lets the front
// half keep accepting until it fills. Configuration writes are always accepted.
module line_filter_fixed_string_top #(
    parameter int MAX_PATTERN = lff_pkg::LFF_MAX_PATTERN,
    parameter int OFFSET_BITS = lff_pkg::LFF_OFFSET_BITS
) (
    input logic         clk,
    input logic         rst_n,
    lff_in_if.sink      in_bytes,
    lff_out_if.source   out_lines,
    lff_cfg_if.sink     cfg
);
    import lff_pkg::*;

    lff_push_t push;
    lff_push_t head;
    logic      queue_full;
    logic      pop;

    // Byte classification.
    lff_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_chan    (in_bytes),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push)
    );

    // Decoupling queue.
    lff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // Line tracking and results.
    lff_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .out_chan (out_lines)
    );

endmodule

[bench/lff_checker.sv]
// Checker for the fixed-string line filter: watches the text, result and register channels,
// predicts each matching line and compares it with what the block returns.
// Depends on lff_pkg and the channel interfaces lff_in_if, lff_out_if and lff_cfg_if.
`timescale 1ns / 1ps

module lff_checker (
    input  logic clk,
    input  logic rst_n,
    lff_in_if    in_bytes,
    lff_out_if   out_lines,
    lff_cfg_if   cfg,
    output int   errors,
    output int   outstanding,
    output int   lines_checked
);
    import lff_pkg::*;

    localparam int WINDOW      = LFF_MAX_PATTERN;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [OUT_FIELD_BITS-1:0] line_offset;
        logic [OUT_FIELD_BITS-1:0] line_length;
        logic [HIT_BITS-1:0]       hit_count;
    } line_rec_t;

    // Copy of the pattern registers, following every accepted write.
    logic [CFG_DATA_BITS-1:0] pat_low;
    logic [CFG_DATA_BITS-1:0] pat_high;
    logic [LEN_BITS-1:0]      pat_len;

    // Stream state of the predicted filter.
    logic [BYTE_BITS-1:0]      window [WINDOW];
    logic [OUT_FIELD_BITS-1:0] next_offset;
    logic [OUT_FIELD_BITS-1:0] line_start;
    logic [HIT_BITS-1:0]       line_hits;
    int unsigned               since_hit;
    logic                      halted;

    line_rec_t expected_lines [$];
    line_rec_t predicted;
    line_rec_t observed;
    int        fail_total;
    int        lines_total;

    function automatic logic [BYTE_BITS-1:0] pattern_at(input int i);
        if (i < 8)
            return pat_low[8*i +: 8];
        if (i < PATTERN_SLOTS)
            return pat_high[8*(i-8) +: 8];
        return ZERO_BYTE;
    endfunction

    // Usable pattern length: clamped to 1..WINDOW and cut at the first zero byte.
    function automatic int active_length();
        int len;
        int i;
        len = int'(pat_len);
        if (len == 0)
            len = 1;
        if (len > WINDOW)
            len = WINDOW;
        for (i = 0; i < len; i++)
            if (pattern_at(i) == ZERO_BYTE)
                return i;
        return len;
    endfunction

    // The newest byte sits at index 0, so the window is read backwards from len-1.
    function automatic bit window_hit(input int len);
        int i;
        if (len == 0)
            return 1'b0;
        for (i = 0; i < len; i++)
            if (window[len-1-i] != pattern_at(i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_stream();
        int i;
        for (i = 0; i < WINDOW; i++)
            window[i] = ZERO_BYTE;
        next_offset = '0;
        line_start  = '0;
        line_hits   = '0;
        since_hit   = WINDOW;
        halted      = 1'b0;
    endfunction

    // Advances the predicted filter by one text byte; returns 1 when a line closes with hits.
    function automatic bit scan_byte(input logic [BYTE_BITS-1:0] b, input logic fin,
                                     output line_rec_t rec);
        int                        len;
        int                        i;
        logic [OUT_FIELD_BITS-1:0] here;
        logic [OUT_FIELD_BITS-1:0] line_end;
        bit                        found;
        len   = active_length();
        here  = next_offset;
        found = 1'b0;
        rec   = '0;
        for (i = WINDOW - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (b == ZERO_BYTE)
            halted = 1'b1;
        if (since_hit < WINDOW)
            since_hit++;
        // Matches only count once the previous one has been left behind.
        if (!halted && since_hit >= len && window_hit(len))
        begin
            since_hit = 0;
            if (line_hits != HIT_MAX)
                line_hits++;
        end
        if (b == NEWLINE_BYTE || fin)
        begin
            line_end = (b == NEWLINE_BYTE) ? here : here + 1'b1;
            if (line_hits != '0)
            begin
                rec.line_offset = line_start;
                rec.line_length = line_end - line_start;
                rec.hit_count   = line_hits;
                found           = 1'b1;
            end
            line_hits  = '0;
            line_start = here + 1'b1;
        end
        next_offset = here + 1'b1;
        if (fin)
            clear_stream();
        return found;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            if (fail_total < SHOW_LIMIT)
                $display("%0t: line result %s wrong: expected %h, got %h", $realtime,
                         field, want, got);
            fail_total++;
        end
    endtask

    // Register writes, then text requests, then returned lines, all at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low  = '0;
            pat_high = '0;
            pat_len  = PATTERN_LENGTH_RESET;
            clear_stream();
            expected_lines.delete();
            fail_total    = 0;
            lines_total   = 0;
            errors        <= 0;
            outstanding   <= 0;
            lines_checked <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    CFG_PATTERN_LOW:    pat_low  = cfg.reg_data;
                    CFG_PATTERN_HIGH:   pat_high = cfg.reg_data;
                    CFG_PATTERN_LENGTH: pat_len  = cfg.reg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_bytes.valid && in_bytes.ready)
            begin
                if (scan_byte(in_bytes.data_byte, in_bytes.last_byte, predicted))
                    expected_lines.push_back(predicted);
            end

            if (out_lines.valid && out_lines.ready)
            begin
                observed.line_offset = out_lines.line_offset;
                observed.line_length = out_lines.line_length;
                observed.hit_count   = out_lines.hit_count;
                if (expected_lines.size() == 0)
                begin
                    if (fail_total < SHOW_LIMIT)
                        $display("%0t: unexpected line result: offset %h length %h hits %h",
                                 $realtime, observed.line_offset, observed.line_length,
                                 observed.hit_count);
                    fail_total++;
                end
                else
                begin
                    predicted = expected_lines.pop_front();
                    compare_field("line_offset", predicted.line_offset, observed.line_offset);
                    compare_field("line_length", predicted.line_length, observed.line_length);
                    compare_field("hit_count", 32'(predicted.hit_count),
                                  32'(observed.hit_count));
                end
                lines_total++;
            end

            errors        <= fail_total;
            outstanding   <= expected_lines.size();
            lines_checked <= lines_total;
        end
    end

endmodule

[bench/tb.sv]
// Top of the line filter testbench: clock, reset, text and register stimulus, result
// back-pressure and the verdict. Depends on lff_pkg, the channel interfaces, lff_checker
// and line_filter_fixed_string_top.
`timescale 1ns / 1ps

module tb;
    import lff_pkg::*;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_BYTES  = 1700;
    localparam int PHASE_BYTES   = 150;
    localparam int SETTLE_CYCLES = 10;
    localparam int N_LENGTHS     = 14;

    localparam logic [BYTE_BITS-1:0] CHAR_A = 8'h61;
    localparam logic [BYTE_BITS-1:0] CHAR_B = 8'h62;
    localparam logic [BYTE_BITS-1:0] ALL_ONES_BYTE = 8'hFF;

    localparam logic [LEN_BITS-1:0] LENGTH_CHOICES [N_LENGTHS] = '{
        5'd1, 5'd2, 5'd3, 5'd16, 5'd0, 5'd17, 5'd31, 5'd8, 5'd9, 5'd4, 5'd15, 5'd2, 5'd1, 5'd5
    };

    logic clk;
    logic rst_n;

    lff_in_if  in_bytes ();
    lff_out_if out_lines ();
    lff_cfg_if cfg ();

    int errors;
    int outstanding;
    int lines_checked;

    int bytes_sent;
    int streams_sent;
    int settings_used;
    bit tx_calm;
    bit rx_calm;

    // Pattern as programmed, used only to shape the text.
    logic [BYTE_BITS-1:0] pat_bytes [PATTERN_SLOTS];
    int                   gen_len;

    line_filter_fixed_string_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bytes  (in_bytes),
        .out_lines (out_lines),
        .cfg       (cfg)
    );

    lff_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_bytes      (in_bytes),
        .out_lines     (out_lines),
        .cfg           (cfg),
        .errors        (errors),
        .outstanding   (outstanding),
        .lines_checked (lines_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result back-pressure: calm phases keep ready high, the others stall at random.
    initial
    begin
        int stall;
        out_lines.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_calm)
            begin
                out_lines.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = pause_cycles();
                if (stall > 0)
                begin
                    out_lines.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_lines.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic fin);
        int gap;
        in_bytes.valid     <= 1'b1;
        in_bytes.data_byte <= b;
        in_bytes.last_byte <= fin;
        do @(posedge clk); while (!in_bytes.ready);
        bytes_sent++;
        if (fin)
            streams_sent++;
        gap = tx_calm ? 0 : pause_cycles();
        if (gap > 0)
        begin
            in_bytes.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input logic fin_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], fin_at_end && (i == s.len() - 1));
    endtask

    // Holds the text back until every predicted line has come out, then waits a little more.
    task automatic wait_for_lines(input int settle);
        in_bytes.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.reg_data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pattern(input logic [CFG_DATA_BITS-1:0] low,
                               input logic [CFG_DATA_BITS-1:0] high,
                               input logic [CFG_DATA_BITS-1:0] len_data);
        int i;
        int n;
        write_reg(CFG_PATTERN_LOW, low);
        write_reg(CFG_PATTERN_HIGH, high);
        write_reg(CFG_PATTERN_LENGTH, len_data);
        for (i = 0; i < 8; i++)
        begin
            pat_bytes[i]     = low[8*i +: 8];
            pat_bytes[i + 8] = high[8*i +: 8];
        end
        n = int'(len_data[LEN_BITS-1:0]);
        if (n == 0)
            n = 1;
        if (n > PATTERN_SLOTS)
            n = PATTERN_SLOTS;
        gen_len = 0;
        while (gen_len < n && pat_bytes[gen_len] != ZERO_BYTE)
            gen_len++;
        settings_used++;
    endtask

    // A pattern of mostly two letters so that runs overlap, sometimes with a newline,
    // all-ones bytes or a zero byte cutting it short.
    task automatic random_setting(input int phase);
        logic [CFG_DATA_BITS-1:0] low;
        logic [CFG_DATA_BITS-1:0] high;
        logic [CFG_DATA_BITS-1:0] len_data;
        logic [BYTE_BITS-1:0]     pick;
        int                       i;
        int                       r;
        for (i = 0; i < PATTERN_SLOTS; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                pick = CHAR_A;
            else if (r < 7)
                pick = CHAR_B;
            else if (r == 7)
                pick = NEWLINE_BYTE;
            else if (r == 8)
                pick = ALL_ONES_BYTE;
            else
                pick = 8'($urandom_range(1, 255));
            if (phase % 9 == 4)
                pick = ALL_ONES_BYTE;
            if (i < 8)
                low[8*i +: 8] = pick;
            else
                high[8*(i-8) +: 8] = pick;
        end
        if (phase % 6 == 5)
        begin
            i = $urandom_range(0, PATTERN_SLOTS - 1);
            if (i < 8)
                low[8*i +: 8] = ZERO_BYTE;
            else
                high[8*(i-8) +: 8] = ZERO_BYTE;
        end
        if (phase % 10 == 7)
            high = '0;
        len_data = {$urandom(), $urandom()};
        len_data[LEN_BITS-1:0] = LENGTH_CHOICES[phase % N_LENGTHS];
        set_pattern(low, high, len_data);
        if (phase == 2)
            write_reg(CFG_UNUSED, {$urandom(), $urandom()});
    endtask

    // One stream of a few lines built largely from pattern pieces, ended by the final-byte flag.
    task automatic send_stream();
        logic [BYTE_BITS-1:0] text [$];
        int                   lines;
        int                   span;
        int                   r;
        int                   i;
        int                   j;
        int                   k;
        lines = $urandom_range(1, 6);
        for (k = 0; k < lines; k++)
        begin
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
            i = 0;
            while (i < span)
            begin
                r = $urandom_range(0, 199);
                if (r < 40 && gen_len > 0)
                begin
                    for (j = 0; j < gen_len; j++)
                        text.push_back(pat_bytes[j]);
                    i += gen_len;
                end
                else if (r < 130 && gen_len > 0)
                begin
                    text.push_back(pat_bytes[$urandom_range(0, gen_len - 1)]);
                    i++;
                end
                else if (r < 199)
                begin
                    text.push_back(8'($urandom_range(1, 255)));
                    i++;
                end
                else
                begin
                    text.push_back(ZERO_BYTE);
                    i++;
                end
            end
            if (k < lines - 1 || $urandom_range(0, 1) == 1)
                text.push_back(NEWLINE_BYTE);
        end
        if (text.size() == 0)
            text.push_back(NEWLINE_BYTE);
        for (i = 0; i < text.size(); i++)
        begin
            send_byte(text[i], i == text.size() - 1);
            // Occasionally let the result side empty completely in mid-stream.
            if (text[i] == NEWLINE_BYTE && $urandom_range(0, 49) == 0)
                wait_for_lines(0);
        end
    endtask

    // Main sequence: reset, directed text, random phases, verdict.
    initial
    begin
        int phase;
        int goal;
        int phase_end;
        int k;

        rst_n              <= 1'b0;
        in_bytes.valid     <= 1'b0;
        in_bytes.data_byte <= '0;
        in_bytes.last_byte <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.reg_index      <= CFG_PATTERN_LOW;
        cfg.reg_data       <= '0;
        tx_calm            = 1'b0;
        rx_calm            = 1'b0;
        bytes_sent         = 0;
        streams_sent       = 0;
        settings_used      = 0;
        for (k = 0; k < PATTERN_SLOTS; k++)
            pat_bytes[k] = ZERO_BYTE;
        gen_len = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern is empty, so nothing may match.
        send_text("ab\n", 1'b0);
        wait_for_lines(SETTLE_CYCLES);

        // Two-letter pattern: repeated hits, an empty line, a zero byte halting the search.
        set_pattern(64'h6261, '1, 64'd2);
        send_text("abab\n", 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0);
        send_text("ab", 1'b0);
        send_byte(ZERO_BYTE, 1'b0);
        send_text("ab\n", 1'b0);
        send_byte(ALL_ONES_BYTE, 1'b1);
        wait_for_lines(SETTLE_CYCLES);

        // Pattern holding a newline: the hit belongs to the line where it ends.
        set_pattern(64'h61_0A_61, '0, 64'd3);
        send_text("xa\nab\n", 1'b1);
        wait_for_lines(SETTLE_CYCLES);

        // A length of zero behaves as one; the stream ends without a newline.
        set_pattern(64'h61, '0, 64'd0);
        send_text("aa", 1'b1);

        // Random phases, each under a fresh pattern setting.
        goal  = bytes_sent + RANDOM_BYTES;
        phase = 0;
        while (bytes_sent < goal)
        begin
            wait_for_lines(SETTLE_CYCLES);
            random_setting(phase);
            tx_calm   = (phase % 4 == 1);
            rx_calm   = (phase % 4 == 1) || (phase % 5 == 3);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_stream();
            phase++;
        end

        wait_for_lines(SETTLE_CYCLES);
        $display("Sent %0d text bytes in %0d streams under %0d pattern settings;",
                 bytes_sent, streams_sent, settings_used);
        $display("%0d matching lines came back and were checked.", lines_checked);
        if (errors == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
